>>> src/bcn_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcn_pkg
// Shared constants and register codes for the bisection crossing-net counter.
// ---------------------------------------------------------------------------
package bcn_pkg;

  localparam int MAX_LEVELS = 4;
  localparam int COORD_BITS = 10;
  localparam int COUNT_BITS = 24;

  localparam int LEVEL_BITS     = 3;
  localparam int APB_ADDR_BITS  = 4;
  localparam int APB_DATA_BITS  = 32;
  localparam int REG_INDEX_BITS = 2;

  localparam int RESET_GRID_WIDTH   = 100;
  localparam int RESET_GRID_HEIGHT  = 100;
  localparam int RESET_SPLIT_LEVELS = 2;

  typedef enum logic [REG_INDEX_BITS-1:0] {
    REG_GRID_WIDTH,
    REG_GRID_HEIGHT,
    REG_SPLIT_LEVELS
  } reg_index_t;

endpackage

>>> src/bcn_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcn_item_if / bcn_result_if
// Valid/ready channels for net bounding boxes and per-net crossing results.
// ---------------------------------------------------------------------------
interface bcn_item_if #(
  parameter int COORD_BITS = bcn_pkg::COORD_BITS
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] x_low;
  logic [COORD_BITS-1:0] x_high;
  logic [COORD_BITS-1:0] y_low;
  logic [COORD_BITS-1:0] y_high;
  logic                  restart;

  modport source (output valid, x_low, x_high, y_low, y_high, restart, input ready);
  modport sink   (input valid, x_low, x_high, y_low, y_high, restart, output ready);
endinterface

interface bcn_result_if #(
  parameter int HIT_BITS   = bcn_pkg::MAX_LEVELS + 1,
  parameter int COUNT_BITS = bcn_pkg::COUNT_BITS
);
  logic                  valid;
  logic                  ready;
  logic                  touches_many;
  logic [HIT_BITS-1:0]   boxes_touched;
  logic [COUNT_BITS-1:0] crossing_total;

  modport source (output valid, touches_many, boxes_touched, crossing_total, input ready);
  modport sink   (input valid, touches_many, boxes_touched, crossing_total, output ready);
endinterface

>>> src/bcn_cfg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcn_cfg
// APB register file holding grid size and bisection depth.
// ---------------------------------------------------------------------------
module bcn_cfg #(
  parameter int COORD_BITS = bcn_pkg::COORD_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bcn_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [bcn_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [bcn_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready,
  output logic [COORD_BITS-1:0]              grid_width,
  output logic [COORD_BITS-1:0]              grid_height,
  output logic [bcn_pkg::LEVEL_BITS-1:0]     split_levels
);

  logic                                 wr_en;
  logic [bcn_pkg::REG_INDEX_BITS-1:0]   reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[bcn_pkg::APB_ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= COORD_BITS'(bcn_pkg::RESET_GRID_WIDTH);
      grid_height  <= COORD_BITS'(bcn_pkg::RESET_GRID_HEIGHT);
      split_levels <= bcn_pkg::LEVEL_BITS'(bcn_pkg::RESET_SPLIT_LEVELS);
    end else if (wr_en) begin
      case (reg_index)
        bcn_pkg::REG_GRID_WIDTH:   grid_width   <= pwdata[COORD_BITS-1:0];
        bcn_pkg::REG_GRID_HEIGHT:  grid_height  <= pwdata[COORD_BITS-1:0];
        bcn_pkg::REG_SPLIT_LEVELS: split_levels <= pwdata[bcn_pkg::LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      bcn_pkg::REG_GRID_WIDTH:   prdata = bcn_pkg::APB_DATA_BITS'(grid_width);
      bcn_pkg::REG_GRID_HEIGHT:  prdata = bcn_pkg::APB_DATA_BITS'(grid_height);
      bcn_pkg::REG_SPLIT_LEVELS: prdata = bcn_pkg::APB_DATA_BITS'(split_levels);
      default:                   prdata = '0;
    endcase
  end

endmodule

>>> src/bcn_box_build.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcn_box_build
// Bisection tree over the grid; registers the partition boxes of the
// selected depth together with a valid bit per box.
// ---------------------------------------------------------------------------
module bcn_box_build #(
  parameter int MAX_LEVELS = bcn_pkg::MAX_LEVELS,
  parameter int COORD_BITS = bcn_pkg::COORD_BITS
) (
  input  logic                             clk,
  input  logic [COORD_BITS-1:0]            grid_width,
  input  logic [COORD_BITS-1:0]            grid_height,
  input  logic [bcn_pkg::LEVEL_BITS-1:0]   split_levels,
  output logic [COORD_BITS:0]              box_xlo [1 << MAX_LEVELS],
  output logic [COORD_BITS:0]              box_xhi [1 << MAX_LEVELS],
  output logic [COORD_BITS:0]              box_ylo [1 << MAX_LEVELS],
  output logic [COORD_BITS:0]              box_yhi [1 << MAX_LEVELS],
  output logic [(1 << MAX_LEVELS)-1:0]     box_valid
);

  localparam int NUM_BOXES = 1 << MAX_LEVELS;
  localparam int BW        = COORD_BITS + 1;

  logic [bcn_pkg::LEVEL_BITS-1:0] lv;
  logic [BW-1:0] node_xlo [MAX_LEVELS+1][NUM_BOXES];
  logic [BW-1:0] node_xhi [MAX_LEVELS+1][NUM_BOXES];
  logic [BW-1:0] node_ylo [MAX_LEVELS+1][NUM_BOXES];
  logic [BW-1:0] node_yhi [MAX_LEVELS+1][NUM_BOXES];
  logic [BW:0]   mid_sum;
  logic [BW-1:0] mid;
  logic [BW-1:0] xlo_next [NUM_BOXES];
  logic [BW-1:0] xhi_next [NUM_BOXES];
  logic [BW-1:0] ylo_next [NUM_BOXES];
  logic [BW-1:0] yhi_next [NUM_BOXES];
  logic [NUM_BOXES-1:0] valid_next;

  always_comb begin
    lv = (split_levels > bcn_pkg::LEVEL_BITS'(MAX_LEVELS)) ?
         bcn_pkg::LEVEL_BITS'(MAX_LEVELS) : split_levels;
    mid_sum = '0;
    mid     = '0;
    for (int d = 0; d <= MAX_LEVELS; d++) begin
      for (int j = 0; j < NUM_BOXES; j++) begin
        node_xlo[d][j] = '0;
        node_xhi[d][j] = '0;
        node_ylo[d][j] = '0;
        node_yhi[d][j] = '0;
      end
    end
    node_xhi[0][0] = BW'(grid_width) + BW'(1);
    node_yhi[0][0] = BW'(grid_height) + BW'(1);

    // even depths cut y, odd depths cut x
    for (int d = 0; d < MAX_LEVELS; d++) begin
      for (int j = 0; j < (1 << d); j++) begin
        if ((d & 1) == 0) begin
          mid_sum = {1'b0, node_ylo[d][j]} + {1'b0, node_yhi[d][j]};
          mid     = mid_sum[BW:1];
          node_xlo[d+1][2*j]   = node_xlo[d][j];
          node_xhi[d+1][2*j]   = node_xhi[d][j];
          node_ylo[d+1][2*j]   = node_ylo[d][j];
          node_yhi[d+1][2*j]   = mid;
          node_xlo[d+1][2*j+1] = node_xlo[d][j];
          node_xhi[d+1][2*j+1] = node_xhi[d][j];
          node_ylo[d+1][2*j+1] = mid + BW'(1);
          node_yhi[d+1][2*j+1] = node_yhi[d][j];
        end else begin
          mid_sum = {1'b0, node_xlo[d][j]} + {1'b0, node_xhi[d][j]};
          mid     = mid_sum[BW:1];
          node_xlo[d+1][2*j]   = node_xlo[d][j];
          node_xhi[d+1][2*j]   = mid;
          node_ylo[d+1][2*j]   = node_ylo[d][j];
          node_yhi[d+1][2*j]   = node_yhi[d][j];
          node_xlo[d+1][2*j+1] = mid + BW'(1);
          node_xhi[d+1][2*j+1] = node_xhi[d][j];
          node_ylo[d+1][2*j+1] = node_ylo[d][j];
          node_yhi[d+1][2*j+1] = node_yhi[d][j];
        end
      end
    end

    // pick the row of the tree at the selected depth
    for (int i = 0; i < NUM_BOXES; i++) begin
      xlo_next[i]   = '0;
      xhi_next[i]   = '0;
      ylo_next[i]   = '0;
      yhi_next[i]   = '0;
      valid_next[i] = 1'b0;
      for (int d = 0; d <= MAX_LEVELS; d++) begin
        if (lv == bcn_pkg::LEVEL_BITS'(d) && i < (1 << d)) begin
          xlo_next[i]   = node_xlo[d][i];
          xhi_next[i]   = node_xhi[d][i];
          ylo_next[i]   = node_ylo[d][i];
          yhi_next[i]   = node_yhi[d][i];
          valid_next[i] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    box_xlo   <= xlo_next;
    box_xhi   <= xhi_next;
    box_ylo   <= ylo_next;
    box_yhi   <= yhi_next;
    box_valid <= valid_next;
  end

endmodule

>>> src/bcn_match.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bcn_match
// Closed-interval overlap of one net box against every partition box,
// and a count of the boxes hit.
// ---------------------------------------------------------------------------
module bcn_match #(
  parameter int MAX_LEVELS = bcn_pkg::MAX_LEVELS,
  parameter int COORD_BITS = bcn_pkg::COORD_BITS
) (
  input  logic [COORD_BITS-1:0]         x_low,
  input  logic [COORD_BITS-1:0]         x_high,
  input  logic [COORD_BITS-1:0]         y_low,
  input  logic [COORD_BITS-1:0]         y_high,
  input  logic [COORD_BITS:0]           box_xlo [1 << MAX_LEVELS],
  input  logic [COORD_BITS:0]           box_xhi [1 << MAX_LEVELS],
  input  logic [COORD_BITS:0]           box_ylo [1 << MAX_LEVELS],
  input  logic [COORD_BITS:0]           box_yhi [1 << MAX_LEVELS],
  input  logic [(1 << MAX_LEVELS)-1:0]  box_valid,
  output logic [MAX_LEVELS:0]           hits
);

  localparam int NUM_BOXES = 1 << MAX_LEVELS;
  localparam int BW        = COORD_BITS + 1;

  logic [BW-1:0]        nxl, nxh, nyl, nyh;
  logic                 net_ok;
  logic [NUM_BOXES-1:0] hit_vec;

  assign nxl    = BW'(x_low);
  assign nxh    = BW'(x_high);
  assign nyl    = BW'(y_low);
  assign nyh    = BW'(y_high);
  assign net_ok = (nxl <= nxh) && (nyl <= nyh);

  always_comb begin
    hits = '0;
    for (int i = 0; i < NUM_BOXES; i++) begin
      hit_vec[i] = net_ok && box_valid[i] &&
                   (box_xlo[i] <= box_xhi[i]) && (box_ylo[i] <= box_yhi[i]) &&
                   (nxl <= box_xhi[i]) && (box_xlo[i] <= nxh) &&
                   (nyl <= box_yhi[i]) && (box_ylo[i] <= nyh);
      hits = hits + (MAX_LEVELS+1)'(hit_vec[i]);
    end
  end

endmodule

>>> src/bisection_crossing_net_counter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bisection_crossing_net_counter
// Counts the bisection partition boxes each net bounding box overlaps and
// keeps a saturating total of nets that touch more than one box.
//
// Channels: net boxes enter on the item channel (valid/ready), one result
// per net leaves on the result channel in the same order. Grid size and
// depth sit in an APB register file (0x0 width, 0x4 height, 0x8 levels).
// Path: input register, compare stage, result register. Throughput: one
// net per cycle while the receiver keeps ready high, set by the single
// compare stage between the input register and the result register.
// Stall: while the receiver holds ready low the result holds; one more net
// is taken into the input register, then item ready drops.
// Reset: clears the total and both pipeline valids and loads the default
// registers; the partition boxes are registered from the registers after
// any write, so a net may follow a register write in the next cycle.
// ---------------------------------------------------------------------------
module bisection_crossing_net_counter #(
  parameter int MAX_LEVELS = bcn_pkg::MAX_LEVELS,
  parameter int COORD_BITS = bcn_pkg::COORD_BITS,
  parameter int COUNT_BITS = bcn_pkg::COUNT_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  bcn_item_if.sink                           item,
  bcn_result_if.source                       result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bcn_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [bcn_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [bcn_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready
);

  localparam int NUM_BOXES = 1 << MAX_LEVELS;
  localparam int HIT_BITS  = MAX_LEVELS + 1;

  logic [COORD_BITS-1:0]          grid_width;
  logic [COORD_BITS-1:0]          grid_height;
  logic [bcn_pkg::LEVEL_BITS-1:0] split_levels;

  logic [COORD_BITS:0]  box_xlo [NUM_BOXES];
  logic [COORD_BITS:0]  box_xhi [NUM_BOXES];
  logic [COORD_BITS:0]  box_ylo [NUM_BOXES];
  logic [COORD_BITS:0]  box_yhi [NUM_BOXES];
  logic [NUM_BOXES-1:0] box_valid;

  logic                  s1_valid;
  logic [COORD_BITS-1:0] s1_x_low, s1_x_high, s1_y_low, s1_y_high;
  logic                  s1_restart;
  logic [HIT_BITS-1:0]   hits;

  logic                  out_valid;
  logic                  out_touches_many;
  logic [HIT_BITS-1:0]   out_boxes_touched;
  logic [COUNT_BITS-1:0] out_crossing_total;

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_base;
  logic [COUNT_BITS-1:0] count_next;
  logic                  many;
  logic                  advance;
  logic                  s1_move;

  bcn_cfg #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .grid_width   (grid_width),
    .grid_height  (grid_height),
    .split_levels (split_levels)
  );

  bcn_box_build #(
    .MAX_LEVELS (MAX_LEVELS),
    .COORD_BITS (COORD_BITS)
  ) u_box_build (
    .clk          (clk),
    .grid_width   (grid_width),
    .grid_height  (grid_height),
    .split_levels (split_levels),
    .box_xlo      (box_xlo),
    .box_xhi      (box_xhi),
    .box_ylo      (box_ylo),
    .box_yhi      (box_yhi),
    .box_valid    (box_valid)
  );

  bcn_match #(
    .MAX_LEVELS (MAX_LEVELS),
    .COORD_BITS (COORD_BITS)
  ) u_match (
    .x_low     (s1_x_low),
    .x_high    (s1_x_high),
    .y_low     (s1_y_low),
    .y_high    (s1_y_high),
    .box_xlo   (box_xlo),
    .box_xhi   (box_xhi),
    .box_ylo   (box_ylo),
    .box_yhi   (box_yhi),
    .box_valid (box_valid),
    .hits      (hits)
  );

  assign advance    = !out_valid || result.ready;
  assign s1_move    = s1_valid && advance;
  assign item.ready = !s1_valid || advance;

  assign many       = hits > HIT_BITS'(1);
  assign count_base = s1_restart ? '0 : count;
  assign count_next = (many && (count_base != {COUNT_BITS{1'b1}})) ?
                      count_base + COUNT_BITS'(1) : count_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (item.ready) begin
        s1_valid <= item.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (s1_move) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_x_low   <= item.x_low;
      s1_x_high  <= item.x_high;
      s1_y_low   <= item.y_low;
      s1_y_high  <= item.y_high;
      s1_restart <= item.restart;
    end
    if (s1_move) begin
      out_touches_many   <= many;
      out_boxes_touched  <= hits;
      out_crossing_total <= count_next;
    end
  end

  assign result.valid          = out_valid;
  assign result.touches_many   = out_touches_many;
  assign result.boxes_touched  = out_boxes_touched;
  assign result.crossing_total = out_crossing_total;

  a_flag_matches_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_touches_many == (out_boxes_touched > HIT_BITS'(1))))
    else $error("touches_many disagrees with boxes_touched");

  a_total_no_drop: assert property (@(posedge clk) disable iff (rst)
    (s1_move && !s1_restart) |=> (count >= $past(count)))
    else $error("crossing total dropped without restart");

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (s1_valid && out_valid && !result.ready))
    else $error("item ready low with room in the pipeline");

  a_total_tracks_count: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> (out_crossing_total == count))
    else $error("result total differs from running count");

endmodule

>>> bench/bisection_crossing_net_counter_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bisection_crossing_net_counter_tb
// Self-checking bench for the bisection crossing-net counter.
//
// Rebuilds the partition boxes for every grid setting, predicts the box
// count, the crossing flag and the running total per net, and compares each
// result transfer against the oldest prediction. Grid settings are swept over
// small, empty, full-scale and over-deep cases through the APB port and read
// back. Both channels idle at random, and one long receiver hold-off backs
// the pipeline up into the item channel.
// ---------------------------------------------------------------------------
module bisection_crossing_net_counter_tb;

  localparam int NUM_BOXES      = 1 << bcn_pkg::MAX_LEVELS;
  localparam int HIT_BITS       = bcn_pkg::MAX_LEVELS + 1;
  localparam int COORD_TOP      = (1 << bcn_pkg::COORD_BITS) - 1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 60;
  localparam int NETS_PER_PLAN  = 60;
  localparam int NUM_PLANS      = 10;
  localparam logic [bcn_pkg::APB_ADDR_BITS-1:0] UNMAPPED_ADDR = {2'b11, 2'b00};

  typedef struct packed {
    logic [bcn_pkg::COORD_BITS-1:0] x_low;
    logic [bcn_pkg::COORD_BITS-1:0] x_high;
    logic [bcn_pkg::COORD_BITS-1:0] y_low;
    logic [bcn_pkg::COORD_BITS-1:0] y_high;
    logic                           restart;
  } net_t;

  typedef struct packed {
    logic                           touches_many;
    logic [HIT_BITS-1:0]            boxes_touched;
    logic [bcn_pkg::COUNT_BITS-1:0] crossing_total;
  } crossing_t;

  class crossing_scoreboard;
    int unsigned grid_w, grid_h, levels;
    int unsigned bx_lo[NUM_BOXES], bx_hi[NUM_BOXES];
    int unsigned by_lo[NUM_BOXES], by_hi[NUM_BOXES];
    int unsigned n_boxes;
    logic [bcn_pkg::COUNT_BITS-1:0] total;
    crossing_t expected_q[$];
    int errors, nets_noted, checked;

    function new();
      grid_w = bcn_pkg::RESET_GRID_WIDTH;
      grid_h = bcn_pkg::RESET_GRID_HEIGHT;
      levels = bcn_pkg::RESET_SPLIT_LEVELS;
      total = '0;
      rebuild();
    endfunction

    function void rebuild();
      int unsigned lv, xl, xh, yl, yh, mid;
      bit upper;
      lv = (levels > bcn_pkg::MAX_LEVELS) ? bcn_pkg::MAX_LEVELS : levels;
      n_boxes = 1 << lv;
      for (int i = 0; i < n_boxes; i++) begin
        xl = 0;
        xh = grid_w + 1;
        yl = 0;
        yh = grid_h + 1;
        for (int k = 0; k < lv; k++) begin
          upper = ((i >> (lv - 1 - k)) & 1) != 0;
          if (k % 2 == 0) begin
            mid = (yl + yh) >> 1;
            if (upper) yl = mid + 1;
            else yh = mid;
          end else begin
            mid = (xl + xh) >> 1;
            if (upper) xl = mid + 1;
            else xh = mid;
          end
        end
        bx_lo[i] = xl;
        bx_hi[i] = xh;
        by_lo[i] = yl;
        by_hi[i] = yh;
      end
    endfunction

    function void write_reg(bcn_pkg::reg_index_t idx,
                            logic [bcn_pkg::APB_DATA_BITS-1:0] data);
      case (idx)
        bcn_pkg::REG_GRID_WIDTH: grid_w = 32'(data[bcn_pkg::COORD_BITS-1:0]);
        bcn_pkg::REG_GRID_HEIGHT: grid_h = 32'(data[bcn_pkg::COORD_BITS-1:0]);
        bcn_pkg::REG_SPLIT_LEVELS: levels = 32'(data[bcn_pkg::LEVEL_BITS-1:0]);
        default: return;
      endcase
      rebuild();
    endfunction

    function int unsigned read_value(bcn_pkg::reg_index_t idx);
      case (idx)
        bcn_pkg::REG_GRID_WIDTH: return grid_w;
        bcn_pkg::REG_GRID_HEIGHT: return grid_h;
        default: return levels;
      endcase
    endfunction

    function bit spans(int unsigned alo, ahi, blo, bhi);
      if (alo > ahi || blo > bhi) return 0;
      return alo <= bhi && blo <= ahi;
    endfunction

    function void note_net(net_t n);
      int unsigned hits, xl, xh, yl, yh;
      crossing_t c;
      hits = 0;
      xl = 32'(n.x_low);
      xh = 32'(n.x_high);
      yl = 32'(n.y_low);
      yh = 32'(n.y_high);
      if (n.restart) total = '0;
      for (int i = 0; i < n_boxes; i++)
        if (spans(xl, xh, bx_lo[i], bx_hi[i]) && spans(yl, yh, by_lo[i], by_hi[i]))
          hits++;
      if (hits > 1 && total != '1) total++;
      c.touches_many = hits > 1;
      c.boxes_touched = hits[HIT_BITS-1:0];
      c.crossing_total = total;
      expected_q.insert(expected_q.size(), c);
      nets_noted++;
    endfunction

    function void check_result(logic tm, logic [HIT_BITS-1:0] bt,
                               logic [bcn_pkg::COUNT_BITS-1:0] tot);
      crossing_t c;
      if (expected_q.size() == 0) begin
        $display("%0t: result transfer with no net outstanding", $time);
        errors++;
        return;
      end
      c = expected_q.pop_front();
      checked++;
      if (tm !== c.touches_many) begin
        $display("%0t: touches_many expected %0d actual %0d", $time, c.touches_many, tm);
        errors++;
      end
      if (bt !== c.boxes_touched) begin
        $display("%0t: boxes_touched expected %0d actual %0d", $time, c.boxes_touched, bt);
        errors++;
      end
      if (tot !== c.crossing_total) begin
        $display("%0t: crossing_total expected %0d actual %0d", $time, c.crossing_total,
                 tot);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [bcn_pkg::APB_ADDR_BITS-1:0] paddr;
  logic [bcn_pkg::APB_DATA_BITS-1:0] pwdata;
  logic [bcn_pkg::APB_DATA_BITS-1:0] prdata;
  logic pready;

  bcn_item_if   item_bus ();
  bcn_result_if result_bus ();

  bisection_crossing_net_counter dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_bus),
    .result  (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  crossing_scoreboard sb = new();
  bit sender_calm;
  bit receiver_calm;
  bit hold_req;
  int idle_cycles;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic int unsigned clip(int unsigned v);
    return (v > COORD_TOP) ? COORD_TOP : v;
  endfunction

  function automatic logic [bcn_pkg::COORD_BITS-1:0] to_coord(int unsigned v);
    int unsigned c;
    c = clip(v);
    return c[bcn_pkg::COORD_BITS-1:0];
  endfunction

  function automatic net_t make_net();
    net_t n;
    int unsigned r, outer_x, outer_y;
    outer_x = clip(sb.grid_w + 1);
    outer_y = clip(sb.grid_h + 1);
    r = $urandom_range(0, 99);
    if (r < 70) begin
      n.x_low = to_coord($urandom_range(0, outer_x));
      n.x_high = to_coord(n.x_low + ($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                           : $urandom_range(0, outer_x)));
      n.y_low = to_coord($urandom_range(0, outer_y));
      n.y_high = to_coord(n.y_low + ($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                           : $urandom_range(0, outer_y)));
    end else if (r < 88) begin
      n.x_low = to_coord($urandom_range(0, COORD_TOP));
      n.x_high = to_coord($urandom_range(0, COORD_TOP));
      n.y_low = to_coord($urandom_range(0, COORD_TOP));
      n.y_high = to_coord($urandom_range(0, COORD_TOP));
    end else begin
      n.x_low = to_coord($urandom_range(0, outer_x));
      n.x_high = to_coord(n.x_low + $urandom_range(0, outer_x));
      n.y_low = to_coord($urandom_range(1, COORD_TOP));
      n.y_high = to_coord($urandom_range(0, n.y_low - 1));
      if ($urandom_range(0, 1)) begin
        {n.x_low, n.x_high, n.y_low, n.y_high} = {n.y_low, n.y_high, n.x_low, n.x_high};
      end
    end
    n.restart = ($urandom_range(0, 19) == 0);
    return n;
  endfunction

  task automatic offer_net(net_t n, bit last);
    int unsigned gap;
    item_bus.valid <= 1'b1;
    item_bus.x_low <= n.x_low;
    item_bus.x_high <= n.x_high;
    item_bus.y_low <= n.y_low;
    item_bus.y_high <= n.y_high;
    item_bus.restart <= n.restart;
    do @(posedge clk); while (!item_bus.ready);
    sb.note_net(n);
    gap = pick_gap(sender_calm);
    if (gap > 0 || last) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic apb_write(logic [bcn_pkg::APB_ADDR_BITS-1:0] addr,
                           logic [bcn_pkg::APB_DATA_BITS-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_check(bcn_pkg::reg_index_t idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== sb.read_value(idx)) begin
      $display("%0t: register %s read expected %0d actual %0d", $time, idx.name(),
               sb.read_value(idx), prdata);
      sb.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_setting(bcn_pkg::reg_index_t idx, int unsigned val);
    logic [bcn_pkg::APB_DATA_BITS-1:0] data, mask;
    mask = (idx == bcn_pkg::REG_SPLIT_LEVELS) ? (1 << bcn_pkg::LEVEL_BITS) - 1
                                              : (1 << bcn_pkg::COORD_BITS) - 1;
    data = ($urandom() & ~mask) | (val & mask);
    apb_write({idx, 2'b00}, data);
    sb.write_reg(idx, data);
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // receiver: random stalls, calm stretches, one long hold-off on request
  initial begin
    result_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        result_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!receiver_calm && $urandom_range(0, 3) == 0) begin
        result_bus.ready <= 1'b0;
        repeat (pick_gap(0) + 1) @(posedge clk);
      end else begin
        result_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready)
      sb.check_result(result_bus.touches_many, result_bus.boxes_touched,
                      result_bus.crossing_total);
  end

  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) ||
        (result_bus.valid && result_bus.ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned plan_w [NUM_PLANS] = '{1, 1021, 0, 1023, 37, 7, 500, 2, 64, 100};
    int unsigned plan_h [NUM_PLANS] = '{1, 1021, 0, 1023, 5, 900, 3, 1021, 64, 100};
    int unsigned plan_l [NUM_PLANS] = '{4, 4, 3, 1, 0, 7, 5, 4, 6, 2};
    net_t directed [$];
    idle_cycles = 0;
    sender_calm = 0;
    receiver_calm = 0;
    hold_req = 0;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    item_bus.valid <= 1'b0;
    item_bus.x_low <= '0;
    item_bus.x_high <= '0;
    item_bus.y_low <= '0;
    item_bus.y_high <= '0;
    item_bus.restart <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    read_check(bcn_pkg::REG_GRID_WIDTH);
    read_check(bcn_pkg::REG_GRID_HEIGHT);
    read_check(bcn_pkg::REG_SPLIT_LEVELS);

    // default grid: cuts at y 50/51, then x 50/51
    directed = '{
      '{10'd0, 10'd0, 10'd0, 10'd0, 1'b1},
      '{10'd0, 10'd1023, 10'd0, 10'd1023, 1'b0},
      '{10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b0},
      '{10'd50, 10'd51, 10'd0, 10'd0, 1'b0},
      '{10'd0, 10'd0, 10'd50, 10'd51, 1'b0},
      '{10'd50, 10'd50, 10'd50, 10'd50, 1'b0},
      '{10'd51, 10'd51, 10'd51, 10'd51, 1'b0},
      '{10'd50, 10'd51, 10'd50, 10'd51, 1'b0},
      '{10'd10, 10'd5, 10'd0, 10'd101, 1'b0},
      '{10'd0, 10'd101, 10'd60, 10'd40, 1'b0},
      '{10'd101, 10'd101, 10'd101, 10'd101, 1'b0},
      '{10'd102, 10'd200, 10'd0, 10'd101, 1'b0},
      '{10'd0, 10'd101, 10'd102, 10'd1023, 1'b0},
      '{10'd0, 10'd101, 10'd0, 10'd101, 1'b1},
      '{10'd1023, 10'd0, 10'd1023, 10'd0, 1'b0},
      '{10'd0, 10'd1023, 10'd0, 10'd0, 1'b0},
      '{10'd512, 10'd512, 10'd0, 10'd1023, 1'b1},
      '{10'd1, 10'd100, 10'd1, 10'd100, 1'b0},
      '{10'd682, 10'd341, 10'd341, 10'd682, 1'b0},
      '{10'd341, 10'd682, 10'd682, 10'd341, 1'b0}
    };
    foreach (directed[i]) offer_net(directed[i], i == directed.size() - 1);
    drain();

    for (int p = 0; p < NUM_PLANS; p++) begin
      if (p == 5) apb_write(UNMAPPED_ADDR, $urandom());
      write_setting(bcn_pkg::REG_GRID_WIDTH, plan_w[p]);
      write_setting(bcn_pkg::REG_GRID_HEIGHT, plan_h[p]);
      write_setting(bcn_pkg::REG_SPLIT_LEVELS, plan_l[p]);
      read_check(bcn_pkg::REG_GRID_WIDTH);
      read_check(bcn_pkg::REG_GRID_HEIGHT);
      read_check(bcn_pkg::REG_SPLIT_LEVELS);
      sender_calm = (p == 1 || p == 4);
      receiver_calm = (p == 4);
      if (p == 1) hold_req = 1;
      for (int i = 0; i < NETS_PER_PLAN; i++) offer_net(make_net(), i == NETS_PER_PLAN - 1);
      drain();
    end

    repeat (5) @(posedge clk);
    $display("tb: %0d nets over %0d grid settings, %0d results compared", sb.nets_noted,
             NUM_PLANS + 1, sb.checked);
    $display("tb: grids from empty to full scale, depths 0 to 7, one long output hold-off");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
